// ===== hdl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, types and state encoding of the port scan detector.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int SOURCE_ENTRIES = 64;
    localparam int PORT_SLOTS     = 16;
    localparam int WINDOW_DEPTH   = 16;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 64;
    localparam int TWIN_W  = 16;
    localparam int LIMIT_W = 5;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT  = 1'b1;

    localparam logic [TWIN_W-1:0]  TIME_WINDOW_RST = 16'd5;
    localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST  = 5'd3;

    localparam int ENTRY_W   = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;
    localparam int SRC_CNT_W = $clog2(SOURCE_ENTRIES + 1);
    localparam int PFILL_W   = $clog2(PORT_SLOTS + 1);
    localparam int RFILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int HEAD_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int PS_DEPTH  = SOURCE_ENTRIES * PORT_SLOTS;
    localparam int TR_DEPTH  = SOURCE_ENTRIES * WINDOW_DEPTH;
    localparam int PS_AW     = (PS_DEPTH > 1) ? $clog2(PS_DEPTH) : 1;
    localparam int TR_AW     = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
    localparam int IDX_W     = (SRC_CNT_W > PFILL_W) ? SRC_CNT_W : PFILL_W;
    localparam int CMP_W0    = (PFILL_W > RFILL_W) ? PFILL_W : RFILL_W;
    localparam int CMP_W     = (CMP_W0 > CNT_W) ? CMP_W0 : CNT_W;

    typedef struct packed {
        logic                 mark;
        logic [PFILL_W-1:0]   pfill;
        logic [HEAD_W-1:0]    head;
        logic [RFILL_W-1:0]   rfill;
    } meta_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_CMP,
        ST_META_RD,
        ST_META_LD,
        ST_PORT_RD,
        ST_PORT_CMP,
        ST_PORT_END,
        ST_PUSH,
        ST_POP_RD,
        ST_POP_CMP,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept_en;
        logic clr_idx;
        logic idx_inc;
        logic key_rd;
        logic sel_hit;
        logic alloc;
        logic meta_clr;
        logic set_full;
        logic meta_rd;
        logic meta_ld;
        logic pslot_rd;
        logic port_add;
        logic ring_push;
        logic ring_rd;
        logic pop;
        logic finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic is_query;
        logic idx_lt_count;
        logic key_match;
        logic tbl_full;
        logic idx_lt_pfill;
        logic port_match;
        logic pfill_lt_max;
        logic rfill_nz;
        logic stale;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/psd_req_if.sv =====
// ----------------------------------------------------------------------------
// psd_req_if
// Input item channel: connection event or query.
// ----------------------------------------------------------------------------
interface psd_req_if;
    import psd_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [ADDR_W-1:0]   source_addr;
    logic [PORT_W-1:0]   dest_port;
    logic [TIME_W-1:0]   event_time;

    modport source (output valid, op, source_addr, dest_port, event_time, input ready);
    modport sink   (input valid, op, source_addr, dest_port, event_time, output ready);
endinterface

// ===== hdl/psd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psd_rsp_if
// Result item channel.
// ----------------------------------------------------------------------------
interface psd_rsp_if;
    import psd_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_intruder;
    logic              table_full;
    logic [CNT_W-1:0]  distinct_ports;
    logic [CNT_W-1:0]  recent_count;

    modport source (output valid, is_intruder, table_full, distinct_ports, recent_count,
                    input ready);
    modport sink   (input valid, is_intruder, table_full, distinct_ports, recent_count,
                    output ready);
endinterface

// ===== hdl/psd_ram.sv =====
// ----------------------------------------------------------------------------
// psd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [WIDTH-1:0]                rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hdl/psd_ctrl.sv =====
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: walks lookup, port-set search, window push and pop per item.
// ----------------------------------------------------------------------------
module psd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  psd_pkg::status_t  sts,
    output psd_pkg::cmd_t     cmd
);
    import psd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (sts.in_fire)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_KEY_RD;
                end
            end
            ST_KEY_RD:
            begin
                if (sts.idx_lt_count)
                begin
                    cmd.key_rd = 1'b1;
                    state_next = ST_KEY_CMP;
                end
                else if (sts.is_query)
                begin
                    cmd.meta_clr = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (sts.tbl_full)
                begin
                    cmd.meta_clr = 1'b1;
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    // new source: empty port set, go straight to insert
                    cmd.alloc  = 1'b1;
                    state_next = ST_PORT_END;
                end
            end
            ST_KEY_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.sel_hit = 1'b1;
                    state_next  = ST_META_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_KEY_RD;
                end
            end
            ST_META_RD:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = ST_META_LD;
            end
            ST_META_LD:
            begin
                cmd.meta_ld = 1'b1;
                cmd.clr_idx = 1'b1;
                state_next  = sts.is_query ? ST_DONE : ST_PORT_RD;
            end
            ST_PORT_RD:
            begin
                if (sts.idx_lt_pfill)
                begin
                    cmd.pslot_rd = 1'b1;
                    state_next   = ST_PORT_CMP;
                end
                else
                begin
                    state_next = ST_PORT_END;
                end
            end
            ST_PORT_CMP:
            begin
                if (sts.port_match)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_PORT_RD;
                end
            end
            ST_PORT_END:
            begin
                cmd.port_add = sts.pfill_lt_max;
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.ring_push = 1'b1;
                state_next    = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                if (sts.rfill_nz)
                begin
                    cmd.ring_rd = 1'b1;
                    state_next  = ST_POP_CMP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP_CMP:
            begin
                if (sts.stale)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== hdl/psd_dp.sv =====
// ----------------------------------------------------------------------------
// psd_dp
// Datapath: item and entry registers, source/port/time memories, result register.
// ----------------------------------------------------------------------------
module psd_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    psd_req_if.sink                         req,
    psd_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::CFG_W-1:0]       cfg_data,
    input  psd_pkg::cmd_t                   cmd,
    output psd_pkg::status_t                sts
);
    import psd_pkg::*;

    logic [TWIN_W-1:0]    twin_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [SRC_CNT_W-1:0] count_reg;
    logic                 out_valid_reg;

    logic                 op_reg;
    logic [ADDR_W-1:0]    key_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ENTRY_W-1:0]   ent_reg;
    meta_t                meta_reg;
    logic                 full_reg;

    logic                 out_mark_reg;
    logic                 out_full_reg;
    logic [CNT_W-1:0]     out_pcnt_reg;
    logic [CNT_W-1:0]     out_rcnt_reg;

    logic [ADDR_W-1:0]    key_rdata;
    logic [PORT_W-1:0]    ps_rdata;
    logic [TIME_W-1:0]    tr_rdata;
    meta_t                meta_rdata;
    meta_t                meta_next;

    logic [PS_AW-1:0]     ps_raddr;
    logic [PS_AW-1:0]     ps_waddr;
    logic [TR_AW-1:0]     tr_raddr;
    logic [TR_AW-1:0]     tr_waddr;

    logic [HEAD_W-1:0]    push_head;
    logic [RFILL_W-1:0]   push_fill;
    logic [RFILL_W:0]     pos_sum;
    logic [HEAD_W-1:0]    push_pos;
    logic [HEAD_W-1:0]    head_inc;
    logic [TIME_W-1:0]    age;
    logic                 hit_limit;
    logic                 take;

    assign take      = cmd.accept_en & req.valid;
    assign req.ready = cmd.accept_en;

    // Head advance with wrap at the window depth
    assign head_inc = (meta_reg.head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : meta_reg.head + 1'b1;

    // Drop the oldest stamp first when the ring is full
    always_comb
    begin
        if (meta_reg.rfill >= RFILL_W'(WINDOW_DEPTH))
        begin
            push_head = head_inc;
            push_fill = RFILL_W'(WINDOW_DEPTH - 1);
        end
        else
        begin
            push_head = meta_reg.head;
            push_fill = meta_reg.rfill;
        end
        pos_sum = (RFILL_W + 1)'(push_head) + (RFILL_W + 1)'(push_fill);
        if (pos_sum >= (RFILL_W + 1)'(WINDOW_DEPTH))
        begin
            push_pos = HEAD_W'(pos_sum - (RFILL_W + 1)'(WINDOW_DEPTH));
        end
        else
        begin
            push_pos = HEAD_W'(pos_sum);
        end
    end

    assign ps_raddr = PS_AW'(ent_reg) * PS_AW'(PORT_SLOTS) + PS_AW'(idx_reg);
    assign ps_waddr = PS_AW'(ent_reg) * PS_AW'(PORT_SLOTS) + PS_AW'(meta_reg.pfill);
    assign tr_raddr = TR_AW'(ent_reg) * TR_AW'(WINDOW_DEPTH) + TR_AW'(meta_reg.head);
    assign tr_waddr = TR_AW'(ent_reg) * TR_AW'(WINDOW_DEPTH) + TR_AW'(push_pos);

    assign age       = time_reg - tr_rdata;
    assign hit_limit = (CMP_W'(meta_reg.pfill) >= CMP_W'(limit_reg))
                    && (CMP_W'(meta_reg.rfill) >= CMP_W'(limit_reg));

    always_comb
    begin
        meta_next      = meta_reg;
        meta_next.mark = meta_reg.mark | hit_limit;
    end

    psd_ram #(.WIDTH(ADDR_W), .DEPTH(SOURCE_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (cmd.alloc),
        .waddr (count_reg[ENTRY_W-1:0]),
        .wdata (key_reg),
        .re    (cmd.key_rd),
        .raddr (idx_reg[ENTRY_W-1:0]),
        .rdata (key_rdata)
    );

    psd_ram #(.WIDTH($bits(meta_t)), .DEPTH(SOURCE_ENTRIES)) u_meta_ram (
        .clk   (clk),
        .we    (cmd.finish),
        .waddr (ent_reg),
        .wdata (meta_next),
        .re    (cmd.meta_rd),
        .raddr (ent_reg),
        .rdata (meta_rdata)
    );

    psd_ram #(.WIDTH(PORT_W), .DEPTH(PS_DEPTH)) u_port_ram (
        .clk   (clk),
        .we    (cmd.port_add),
        .waddr (ps_waddr),
        .wdata (port_reg),
        .re    (cmd.pslot_rd),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    psd_ram #(.WIDTH(TIME_W), .DEPTH(TR_DEPTH)) u_time_ram (
        .clk   (clk),
        .we    (cmd.ring_push),
        .waddr (tr_waddr),
        .wdata (time_reg),
        .re    (cmd.ring_rd),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twin_reg      <= TIME_WINDOW_RST;
            limit_reg     <= SCAN_LIMIT_RST;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_WINDOW: twin_reg  <= cfg_data[TWIN_W-1:0];
                    CFG_SCAN_LIMIT:  limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:         twin_reg  <= twin_reg;
                endcase
            end
            if (cmd.alloc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item and entry payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= req.op;
            key_reg  <= req.source_addr;
            port_reg <= req.dest_port;
            time_reg <= req.event_time;
            full_reg <= 1'b0;
        end
        if (cmd.clr_idx)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.sel_hit)
        begin
            ent_reg <= idx_reg[ENTRY_W-1:0];
        end
        if (cmd.alloc)
        begin
            ent_reg  <= count_reg[ENTRY_W-1:0];
            meta_reg <= '0;
        end
        if (cmd.meta_clr)
        begin
            meta_reg <= '0;
        end
        if (cmd.set_full)
        begin
            full_reg <= 1'b1;
        end
        if (cmd.meta_ld)
        begin
            meta_reg <= meta_rdata;
        end
        if (cmd.port_add)
        begin
            meta_reg.pfill <= meta_reg.pfill + 1'b1;
        end
        if (cmd.ring_push)
        begin
            meta_reg.head  <= push_head;
            meta_reg.rfill <= push_fill + 1'b1;
        end
        if (cmd.pop)
        begin
            meta_reg.head  <= head_inc;
            meta_reg.rfill <= meta_reg.rfill - 1'b1;
        end
        if (cmd.finish)
        begin
            meta_reg.mark <= meta_next.mark;
        end
        if (cmd.out_load)
        begin
            out_mark_reg <= meta_reg.mark;
            out_full_reg <= full_reg;
            out_pcnt_reg <= (CMP_W'(meta_reg.pfill) > CMP_W'(31)) ? CNT_W'(31)
                                                                 : CNT_W'(meta_reg.pfill);
            out_rcnt_reg <= (CMP_W'(meta_reg.rfill) > CMP_W'(31)) ? CNT_W'(31)
                                                                 : CNT_W'(meta_reg.rfill);
        end
    end

    assign sts.in_fire      = take;
    assign sts.is_query     = op_reg;
    assign sts.idx_lt_count = (IDX_W'(count_reg) > idx_reg);
    assign sts.key_match    = (key_rdata == key_reg);
    assign sts.tbl_full     = (count_reg == SRC_CNT_W'(SOURCE_ENTRIES));
    assign sts.idx_lt_pfill = (IDX_W'(meta_reg.pfill) > idx_reg);
    assign sts.port_match   = (ps_rdata == port_reg);
    assign sts.pfill_lt_max = (meta_reg.pfill < PFILL_W'(PORT_SLOTS));
    assign sts.rfill_nz     = (meta_reg.rfill != '0);
    assign sts.stale        = (age > TIME_W'(twin_reg));
    assign sts.out_free     = ~out_valid_reg | rsp.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.is_intruder    = out_mark_reg;
    assign rsp.table_full     = out_full_reg;
    assign rsp.distinct_ports = out_pcnt_reg;
    assign rsp.recent_count   = out_rcnt_reg;
endmodule

// ===== hdl/port_scan_detector.sv =====
// ----------------------------------------------------------------------------
// port_scan_detector
// Per-source port scan detector with a sliding timestamp window per source.
// ----------------------------------------------------------------------------
//   channel  dir   handshake        payload
//   req      in    valid/ready      op, source_addr, dest_port, event_time
//   rsp      out   valid/ready      is_intruder, table_full, distinct_ports,
//                                   recent_count
//   cfg      in    cfg_we           cfg_index, cfg_data (no read-back)
//
// One item at a time: the key table is searched entry by entry; a query then
// loads the entry's state, while a connection also compares its port slots,
// adds the port if it is new and a slot is free, pushes its timestamp and pops
// stale ones from the window. Each step is one read of a single-read-port
// memory. A result not yet taken holds the next result back. Reset clears the
// source count and result valid and restores the two settings only.
// ----------------------------------------------------------------------------
module port_scan_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    psd_req_if.sink                         req,
    psd_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::CFG_W-1:0]       cfg_data
);
    import psd_pkg::*;

    // Command and status between sequencer and datapath
    cmd_t    cmd;
    status_t sts;

    psd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    psd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ===== test/psd_tb_if.sv =====
// ----------------------------------------------------------------------------
// psd_tb_if
// Testbench-side item types for the request and result channels.
// ----------------------------------------------------------------------------
// The block's own channel interfaces are used directly; this file holds the
// item types shared by the stimulus and the checker.
package psd_tb_pkg;
    import psd_pkg::*;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] source_addr;
        logic [PORT_W-1:0] dest_port;
        logic [TIME_W-1:0] event_time;
    } scan_req_t;

    typedef struct packed {
        logic             is_intruder;
        logic             table_full;
        logic [CNT_W-1:0] distinct_ports;
        logic [CNT_W-1:0] recent_count;
    } scan_rsp_t;

    localparam logic OP_CONNECT = 1'b0;
    localparam logic OP_QUERY   = 1'b1;
endpackage

// ===== test/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Watches both channels, predicts each result and compares it.
// ----------------------------------------------------------------------------
module psd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    psd_req_if                             req,
    psd_rsp_if                             rsp,
    input  logic                           cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psd_pkg::CFG_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import psd_pkg::*;
    import psd_tb_pkg::*;

    logic [ADDR_W-1:0]  src_key   [SOURCE_ENTRIES];
    logic               src_used  [SOURCE_ENTRIES];
    logic               src_flag  [SOURCE_ENTRIES];
    logic [PORT_W-1:0]  port_set  [SOURCE_ENTRIES][PORT_SLOTS];
    int                 port_cnt  [SOURCE_ENTRIES];
    logic [TIME_W-1:0]  stamps    [SOURCE_ENTRIES][WINDOW_DEPTH];
    int                 win_head  [SOURCE_ENTRIES];
    int                 win_cnt   [SOURCE_ENTRIES];
    logic [TWIN_W-1:0]  win_span;
    logic [LIMIT_W-1:0] mark_limit;
    scan_rsp_t          expected_q[$];

    function automatic scan_rsp_t entry_view(int e);
        scan_rsp_t r;
        r.is_intruder    = src_flag[e];
        r.table_full     = 1'b0;
        r.distinct_ports = CNT_W'(port_cnt[e] > 31 ? 31 : port_cnt[e]);
        r.recent_count   = CNT_W'(win_cnt[e] > 31 ? 31 : win_cnt[e]);
        return r;
    endfunction

    // Advance the table by one item and return what the block must report.
    function automatic scan_rsp_t track_source(scan_req_t it);
        scan_rsp_t r;
        int   e;
        logic hit;
        e = -1;
        r = '0;
        for (int i = 0; i < SOURCE_ENTRIES; i++)
            if (e < 0 && src_used[i] && src_key[i] == it.source_addr)
                e = i;
        if (it.op == OP_QUERY)
            return (e >= 0) ? entry_view(e) : r;
        if (e < 0)
        begin
            for (int i = 0; i < SOURCE_ENTRIES; i++)
                if (e < 0 && !src_used[i])
                    e = i;
            if (e < 0)
            begin
                r.table_full = 1'b1;
                return r;
            end
            src_used[e] = 1'b1;
            src_key[e]  = it.source_addr;
            src_flag[e] = 1'b0;
            port_cnt[e] = 0;
            win_head[e] = 0;
            win_cnt[e]  = 0;
        end
        hit = 1'b0;
        for (int i = 0; i < port_cnt[e]; i++)
            if (port_set[e][i] == it.dest_port)
                hit = 1'b1;
        if (!hit && port_cnt[e] < PORT_SLOTS)
        begin
            port_set[e][port_cnt[e]] = it.dest_port;
            port_cnt[e]++;
        end
        if (win_cnt[e] >= WINDOW_DEPTH)
        begin
            win_head[e] = (win_head[e] + 1) % WINDOW_DEPTH;
            win_cnt[e]  = WINDOW_DEPTH - 1;
        end
        stamps[e][(win_head[e] + win_cnt[e]) % WINDOW_DEPTH] = it.event_time;
        win_cnt[e]++;
        while (win_cnt[e] > 0 &&
               TIME_W'(it.event_time - stamps[e][win_head[e]]) > TIME_W'(win_span))
        begin
            win_head[e] = (win_head[e] + 1) % WINDOW_DEPTH;
            win_cnt[e]--;
        end
        if (port_cnt[e] >= mark_limit && win_cnt[e] >= mark_limit)
            src_flag[e] = 1'b1;
        return entry_view(e);
    endfunction

    task automatic report(string what, scan_rsp_t got, scan_rsp_t want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        scan_req_t it;
        scan_rsp_t got, want;
        if (!rst_n)
        begin
            fail_count = 0;
            win_span   = TIME_WINDOW_RST;
            mark_limit = SCAN_LIMIT_RST;
            expected_q.delete();
            for (int i = 0; i < SOURCE_ENTRIES; i++)
            begin
                src_used[i] = 1'b0;
                src_flag[i] = 1'b0;
                port_cnt[i] = 0;
                win_head[i] = 0;
                win_cnt[i]  = 0;
            end
        end
        else
        begin
            // check the result first: it left the block before this transfer
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.is_intruder, rsp.table_full, rsp.distinct_ports, rsp.recent_count};
                if (expected_q.size() == 0)
                    report("unexpected result", got, '0);
                else
                begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (got.is_intruder != want.is_intruder)
                        report("is_intruder", got, want);
                    if (got.table_full != want.table_full)
                        report("table_full", got, want);
                    if (got.distinct_ports != want.distinct_ports)
                        report("distinct_ports", got, want);
                    if (got.recent_count != want.recent_count)
                        report("recent_count", got, want);
                end
            end
            if (req.valid && req.ready)
            begin
                it = {req.op, req.source_addr, req.dest_port, req.event_time};
                expected_q.insert(expected_q.size(), track_source(it));
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIME_WINDOW)
                    win_span = cfg_data[TWIN_W-1:0];
                else if (cfg_index == CFG_SCAN_LIMIT)
                    mark_limit = cfg_data[LIMIT_W-1:0];
            end
        end
    end
endmodule

// ===== test/tb_port_scan_detector.sv =====
// ----------------------------------------------------------------------------
// tb_port_scan_detector
// Directed and random traffic for the port scan detector with random gaps
// and result stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_port_scan_detector;
    import psd_pkg::*;
    import psd_tb_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   stall_mode;
    logic                 hold_off;

    psd_req_if req ();
    psd_rsp_if rsp ();

    port_scan_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    psd_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the worst-case item processing plus stalls.
    initial
    begin
        #10000000;
        $display("port_scan_detector test failed");
        $finish;
    end

    // Receiver: stall on a pattern that changes per phase; hold off for a long
    // stretch on request so the block backs up and stalls its input.
    initial
    begin
        int cyc;
        cyc = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_off)
                rsp.ready <= 1'b0;
            else
                case (stall_mode)
                    0: rsp.ready <= 1'b1;
                    1: rsp.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp.ready <= (cyc % 7 < 3);
                    default: rsp.ready <= ($urandom_range(0, 9) == 0);
                endcase
        end
    end

    // Long hold-off, counted in its own process.
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000) @(negedge clk);
        hold_off = 1'b1;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
    end

    int burst_left;

    // Offer one item; the sender idles between bursts of random length.
    task automatic send_item(scan_req_t it);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        req.valid       <= 1'b1;
        req.op          <= it.op;
        req.source_addr <= it.source_addr;
        req.dest_port   <= it.dest_port;
        req.event_time  <= it.event_time;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left == 0)
            req.valid <= 1'b0;
    endtask

    task automatic send_fields(logic op, logic [31:0] a, logic [15:0] p, logic [63:0] t);
        scan_req_t it;
        it = {op, a, p, t};
        send_item(it);
    endtask

    // Drop valid, drain all results, then allow the block to settle.
    task automatic drain();
        if (burst_left != 0)
            req.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    logic [31:0] addr_pool [8];

    // Random connection burst: a small pool of sources scanning many ports
    // with clustered timestamps, plus occasional noise across the full ranges.
    task automatic random_phase(int count);
        logic [63:0] clock_now;
        logic [31:0] a;
        logic [15:0] p;
        logic [63:0] t;
        clock_now = {$urandom, $urandom};
        for (int k = 0; k < count; k++)
        begin
            clock_now += $urandom_range(0, 4);
            a = addr_pool[$urandom_range(0, 7)];
            p = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20));
            t = clock_now;
            case ($urandom_range(0, 9))
                0: t = {$urandom, $urandom};
                1: t = clock_now - $urandom_range(0, 20);
                2: a = $urandom;
                default: ;
            endcase
            send_fields($urandom_range(0, 4) == 0 ? OP_QUERY : OP_CONNECT, a, p, t);
        end
    endtask

    initial
    begin
        req.valid       = 1'b0;
        req.op          = OP_CONNECT;
        req.source_addr = '0;
        req.dest_port   = '0;
        req.event_time  = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_TIME_WINDOW;
        cfg_data        = '0;
        stall_mode      = 0;
        burst_left      = 0;
        rst_n           = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, unknown query, scan to intruder, extremes.
        send_fields(OP_QUERY, 32'h0A000001, 16'hFFFF, '1);
        for (int i = 0; i < 4; i++)
            send_fields(OP_CONNECT, 32'h0A000001, 16'(i), 64'(i));
        send_fields(OP_CONNECT, 32'h0A000001, 16'd1, 64'd3);
        send_fields(OP_QUERY, 32'h0A000001, 16'h0, 64'h0);
        send_fields(OP_CONNECT, 32'hFFFFFFFF, 16'hFFFF, 64'hFFFFFFFFFFFFFFFF);
        send_fields(OP_CONNECT, 32'hFFFFFFFF, 16'h0000, 64'h0000000000000002);
        send_fields(OP_CONNECT, 32'h00000000, 16'h8000, 64'h8000000000000000);
        // out of order: older time far ahead wraps and pops
        send_fields(OP_CONNECT, 32'h00000000, 16'h8001, 64'h7FFFFFFFFFFFFFF0);
        send_fields(OP_QUERY, 32'hFFFFFFFF, 16'hFFFF, '1);
        drain();

        // Zero limit and zero window: every event marks, and both equal stamps stay in the window.
        write_reg(CFG_SCAN_LIMIT, 16'd0);
        write_reg(CFG_TIME_WINDOW, 16'd0);
        send_fields(OP_CONNECT, 32'h0B000000, 16'd7, 64'd100);
        send_fields(OP_CONNECT, 32'h0B000000, 16'd7, 64'd100);
        drain();

        // Limit above capacity, widest window: window and port set saturate.
        write_reg(CFG_SCAN_LIMIT, 16'd31);
        write_reg(CFG_TIME_WINDOW, 16'hFFFF);
        for (int i = 0; i < 20; i++)
            send_fields(OP_CONNECT, 32'h0C000000, 16'(i * 3), 64'(1000 + i));
        drain();

        // Limit at capacity: mark only after full port set and full window.
        write_reg(CFG_SCAN_LIMIT, 16'd16);
        for (int i = 0; i < 18; i++)
            send_fields(OP_CONNECT, 32'h0D000000, 16'(i), 64'(50 + i));
        drain();

        // Random phases across settings and receiver patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int j = 0; j < 8; j++)
                addr_pool[j] = (ph % 2) ? $urandom : 32'(ph * 16 + j);
            write_reg(CFG_TIME_WINDOW, ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 40)));
            write_reg(CFG_SCAN_LIMIT, ph == 5 ? 16'd17 : 16'($urandom_range(0, 8)));
            stall_mode = ph % 4;
            random_phase(185);
            drain();
        end

        // Fill the table with fresh sources until it overflows.
        stall_mode = 1;
        for (int i = 0; i < 70; i++)
            send_fields(OP_CONNECT, 32'h50000000 + 32'(i), 16'(i), 64'(i));
        send_fields(OP_QUERY, 32'h5FFFFFFF, 16'h0, 64'h0);
        drain();

        if (fail_count == 0)
            $display("port_scan_detector test passed");
        else
            $display("port_scan_detector test failed");
        $finish;
    end
endmodule
